FILE: src/brlewc_pkg.sv
// Shared types, constants and helper functions of the run-length width chooser.
package brlewc_pkg;

   // Number of candidate word widths (1, 2, 4 and 8 bytes).
   localparam int NUM_WIDTHS = 4;
   localparam int WIDTH_CODE_BITS = 2;

   // Run lengths and run counts saturate at the record sample limit.
   localparam int COUNT_BITS = 17;
   localparam int KEY_BITS = 15;
   localparam int ALLELE_BITS = 8;
   localparam int SUB_BITS = 3;
   localparam int COST_BITS = COUNT_BITS + NUM_WIDTHS - 1;

   // Configuration register indexes.
   localparam logic CSR_HAS_MISSING = 1'b0;
   localparam logic CSR_MIXED_PHASING = 1'b1;

   // Word width in bits for each width code.
   localparam int WIDTH_BITS [NUM_WIDTHS] = '{8, 16, 32, 64};

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef count_type [NUM_WIDTHS-1:0] count_array_type;
   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [WIDTH_CODE_BITS-1:0] width_code_type;
   typedef logic [COST_BITS-1:0] cost_type;

   localparam count_type MAX_SAMPLES = 17'd65536;

   // Control that travels with one sample into the run counter.
   typedef struct packed {
      logic step;
      logic last;
      logic has_missing;
      logic mixed_phasing;
   } step_ctrl_type;

   // Increment that sticks at the sample limit.
   function automatic count_type sat_inc(input count_type v);
      if (v >= MAX_SAMPLES) begin
         return MAX_SAMPLES;
      end
      return v + count_type'(1);
   endfunction

   // Longest run a word of the given width can hold, clipped to the count range.
   function automatic count_type width_cap(input width_code_type w,
                                           input logic [SUB_BITS-1:0] sub);
      int exp_bits;
      exp_bits = WIDTH_BITS[w] - int'(sub);
      if (exp_bits >= COUNT_BITS) begin
         return '1;
      end
      return COUNT_BITS'((32'd1 << exp_bits) - 32'd1);
   endfunction

endpackage

FILE: src/brlewc_run_counter.sv
// Per-record run tracking at all four word widths.
module brlewc_run_counter (
   input  logic                            clock,
   input  logic                            reset,
   input  brlewc_pkg::step_ctrl_type       ctrl,
   input  brlewc_pkg::key_type             key,
   output brlewc_pkg::count_array_type     runs_total
);

   logic                          seen_first_ff;
   logic                          seen_first_in;
   brlewc_pkg::key_type           prev_key_ff;
   brlewc_pkg::key_type           prev_key_in;
   brlewc_pkg::count_array_type   run_lengths_ff;
   brlewc_pkg::count_array_type   run_lengths_in;
   brlewc_pkg::count_array_type   run_counts_ff;
   brlewc_pkg::count_array_type   run_counts_in;
   brlewc_pkg::count_array_type   len_upd;
   brlewc_pkg::count_array_type   cnt_upd;
   logic [brlewc_pkg::SUB_BITS-1:0] sub;
   logic                          run_break;

   // Exponent reduction: two allele fields plus an optional phase bit.
   assign sub = (ctrl.has_missing ? 3'd4 : 3'd2) + {2'b00, ctrl.mixed_phasing};
   assign run_break = (key != prev_key_ff);

   // Close runs on a key change or when a width's cap is reached.
   always_comb begin
      for (int w = 0; w < brlewc_pkg::NUM_WIDTHS; w++) begin
         if (!seen_first_ff) begin
            len_upd[w] = brlewc_pkg::count_type'(1);
            cnt_upd[w] = '0;
         end else begin
            len_upd[w] = run_lengths_ff[w];
            cnt_upd[w] = run_counts_ff[w];
            if (run_break) begin
               cnt_upd[w] = brlewc_pkg::sat_inc(cnt_upd[w]);
               len_upd[w] = '0;
            end
            if (len_upd[w] >= brlewc_pkg::width_cap(brlewc_pkg::width_code_type'(w), sub)) begin
               cnt_upd[w] = brlewc_pkg::sat_inc(cnt_upd[w]);
               len_upd[w] = '0;
            end
            len_upd[w] = brlewc_pkg::sat_inc(len_upd[w]);
         end
         // The open run counts too when the record ends here.
         runs_total[w] = brlewc_pkg::sat_inc(cnt_upd[w]);
      end
   end

   // Next state: a record end clears everything but the previous key.
   always_comb begin
      seen_first_in  = seen_first_ff;
      prev_key_in    = prev_key_ff;
      run_lengths_in = run_lengths_ff;
      run_counts_in  = run_counts_ff;
      if (ctrl.step) begin
         prev_key_in = key;
         if (ctrl.last) begin
            seen_first_in  = 1'b0;
            run_lengths_in = '0;
            run_counts_in  = '0;
         end else begin
            seen_first_in  = 1'b1;
            run_lengths_in = len_upd;
            run_counts_in  = cnt_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_first_ff  <= 1'b0;
         prev_key_ff    <= '0;
         run_lengths_ff <= '0;
         run_counts_ff  <= '0;
      end else begin
         seen_first_ff  <= seen_first_in;
         prev_key_ff    <= prev_key_in;
         run_lengths_ff <= run_lengths_in;
         run_counts_ff  <= run_counts_in;
      end
   end

endmodule

FILE: src/brlewc_width_pick.sv
// Cheapest-width selection and the result register.
module brlewc_width_pick (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  brlewc_pkg::count_array_type   runs_total,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output brlewc_pkg::width_code_type    width_code,
   output brlewc_pkg::count_type         run_count
);

   logic                         valid_ff;
   logic                         valid_in;
   brlewc_pkg::width_code_type   code_ff;
   brlewc_pkg::width_code_type   code_in;
   brlewc_pkg::count_type        count_ff;
   brlewc_pkg::count_type        count_in;
   brlewc_pkg::cost_type         best_cost;
   brlewc_pkg::cost_type         cost;

   // Cost is runs times bytes; a tie keeps the narrower width.
   always_comb begin
      best_cost = brlewc_pkg::cost_type'(runs_total[0]);
      code_in   = '0;
      count_in  = runs_total[0];
      cost      = '0;
      for (int w = 1; w < brlewc_pkg::NUM_WIDTHS; w++) begin
         cost = brlewc_pkg::cost_type'(runs_total[w]) << w;
         if (cost < best_cost) begin
            best_cost = cost;
            code_in   = brlewc_pkg::width_code_type'(w);
            count_in  = runs_total[w];
         end
      end
   end

   // A new beat loads; a taken beat empties the register.
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff  <= code_in;
         count_ff <= count_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign width_code = code_ff;
   assign run_count  = count_ff;

endmodule

FILE: src/biallelic_rle_width_chooser.sv
// Top level: input register, configuration registers, run counter and width pick.
// An accepted beat waits in the input register; when it advances and ends a record, its
// result is loaded into the result register and rsp_tvalid rises.
// Throughput: one sample per cycle; the input register advances whenever it holds a sample
// that ends no record, or the result register is empty or being taken.
// Reset is synchronous, active high, and clears configuration, record state and
// both valid flags.
module biallelic_rle_width_chooser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // first_allele [7:0], second_allele [15:8]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // width_code [1:0], run_count [18:2], zero fill
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   logic                                    in_valid_ff;
   logic                                    in_valid_in;
   logic [brlewc_pkg::ALLELE_BITS-1:0]      first_ff;
   logic [brlewc_pkg::ALLELE_BITS-1:0]      second_ff;
   logic                                    last_ff;
   logic                                    has_missing_ff;
   logic                                    mixed_phasing_ff;
   logic                                    stage_go;
   logic                                    req_fire;
   brlewc_pkg::key_type                     key;
   brlewc_pkg::step_ctrl_type               ctrl;
   brlewc_pkg::count_array_type             runs_total;
   brlewc_pkg::width_code_type              width_code;
   brlewc_pkg::count_type                   run_count;

   // The held sample moves on unless it ends a record and the result is stalled.
   assign stage_go   = in_valid_ff && (!last_ff || !rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || stage_go;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (stage_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         first_ff  <= req_tdata[7:0];
         second_ff <= req_tdata[15:8];
         last_ff   <= req_tlast;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         has_missing_ff   <= 1'b0;
         mixed_phasing_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            brlewc_pkg::CSR_HAS_MISSING:   has_missing_ff   <= csr_wdata;
            brlewc_pkg::CSR_MIXED_PHASING: mixed_phasing_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Key: both allele codes, plus the second phase bit under mixed phasing.
   assign key = {second_ff[7:1], first_ff[7:1], mixed_phasing_ff & second_ff[0]};

   assign ctrl.step          = stage_go;
   assign ctrl.last          = last_ff;
   assign ctrl.has_missing   = has_missing_ff;
   assign ctrl.mixed_phasing = mixed_phasing_ff;

   brlewc_run_counter u_run_counter (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .key        (key),
      .runs_total (runs_total)
   );

   brlewc_width_pick u_width_pick (
      .clock      (clock),
      .reset      (reset),
      .load       (stage_go && last_ff),
      .runs_total (runs_total),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .width_code (width_code),
      .run_count  (run_count)
   );

   assign rsp_tdata = {5'b00000, run_count, width_code};

endmodule
